FILE: rtl/pmx_pkg.sv
// Shared types, constants and elaboration-time tables for the precession matrix pipeline.
`timescale 1ns / 1ps

package pmx_pkg;

    typedef logic signed [63:0] t_q64;
    typedef logic signed [31:0] t_entry;

    // one CORDIC cell's payload
    typedef struct packed {
        t_q64 x;
        t_q64 y;
        t_q64 a;
        logic flip;
    } t_rot;

    localparam int MUL_LAT    = 4;

    // round(arc * 4096 / 648000) == round(arc * 64 / 10125), taken as a product with the
    // rounded-up reciprocal of 10125 in Q.75
    localparam int   ARC_SHIFT = 75;
    localparam t_q64 ARC_RECIP = t_q64'(((128'd1 << ARC_SHIFT) + 128'd10124) / 128'd10125);

    localparam t_q64 PI_Q61      = 64'sh6487ED5110B4611A;
    localparam t_q64 PI_Q56      = (PI_Q61 + 64'sd16) >>> 5;
    localparam t_q64 HALF_PI_Q56 = (PI_Q61 + 64'sd32) >>> 6;
    localparam t_q64 ATAN0_Q56   = (PI_Q61 + 64'sd64) >>> 7;

    localparam logic [63:0] INV_SQRT2_Q62 = 64'h2D413CCCFE779921;
    localparam logic [63:0] ONE_Q62       = 64'h4000000000000000;

    localparam t_q64 ROUND_Q30 = 64'sd536870912;
    localparam t_q64 ENTRY_MAX = 64'sd1073741824;
    localparam t_q64 ENTRY_MIN = -64'sd1073741824;

    // polynomial coefficients in Q.32, lanes: zeta, theta, z
    localparam t_q64 C_ZE1 = (64'sd23062181 * 64'sd4294967296 + 64'sd5000) / 64'sd10000;
    localparam t_q64 C_ZE2 = (64'sd30188 * 64'sd4294967296 + 64'sd50000) / 64'sd100000;
    localparam t_q64 C_ZE3 = (64'sd17998 * 64'sd4294967296 + 64'sd500000) / 64'sd1000000;
    localparam t_q64 C_TH1 = (64'sd20043109 * 64'sd4294967296 + 64'sd5000) / 64'sd10000;
    localparam t_q64 C_TH2 = -((64'sd42665 * 64'sd4294967296 + 64'sd50000) / 64'sd100000);
    localparam t_q64 C_TH3 = -((64'sd41833 * 64'sd4294967296 + 64'sd500000) / 64'sd1000000);
    localparam t_q64 C_Z1  = C_ZE1;
    localparam t_q64 C_Z2  = (64'sd109468 * 64'sd4294967296 + 64'sd50000) / 64'sd100000;
    localparam t_q64 C_Z3  = (64'sd18203 * 64'sd4294967296 + 64'sd500000) / 64'sd1000000;

    localparam t_q64 COEF1 [3] = '{C_ZE1, C_TH1, C_Z1};
    localparam t_q64 COEF2 [3] = '{C_ZE2, C_TH2, C_Z2};
    localparam t_q64 COEF3 [3] = '{C_ZE3, C_TH3, C_Z3};

    // restoring unsigned divide, elaboration only
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(a * b / 2^s) half away from zero, saturating magnitude
    function automatic t_q64 f_mulq(input t_q64 a, input t_q64 b, input int s);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [127:0] sh;
        logic [63:0]  r;
        neg = a[63] ^ b[63];
        ua  = a[63] ? 64'(-a) : 64'(a);
        ub  = b[63] ? 64'(-b) : 64'(b);
        p   = 128'(ua) * 128'(ub);
        p   = p + (128'd1 << (s - 1));
        sh  = p >> s;
        r   = sh[63:0];
        if (|sh[127:63]) begin
            r = 64'h7FFFFFFFFFFFFFFF;
        end
        return neg ? -$signed(r) : $signed(r);
    endfunction

    // atan(2^-i) in Q.56
    function automatic t_q64 f_atan_pow2(input int i);
        logic [63:0] acc;
        logic [63:0] t;
        int k;
        acc = '0;
        if (i == 0) begin
            return ATAN0_Q56;
        end
        for (k = 0; k < 32; k++) begin
            if (i * (2 * k + 1) <= 62) begin
                t   = f_udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
                acc = k[0] ? acc - t : acc + t;
            end
        end
        return $signed((acc + 64'd32) >> 6);
    endfunction

    // 1/sqrt(1 + 4^-i) in Q.62
    function automatic logic [63:0] f_gain(input int i);
        logic [63:0] acc;
        logic [63:0] t;
        int n;
        acc = ONE_Q62;
        t   = ONE_Q62;
        if (i == 0) begin
            return INV_SQRT2_Q62;
        end
        if (2 * i > 62) begin
            return ONE_Q62;
        end
        for (n = 1; n < 64; n++) begin
            if (t != 64'd0) begin
                t   = f_udiv((t >> (2 * i)) * 64'(2 * n - 1), 64'(2 * n));
                acc = n[0] ? acc - t : acc + t;
            end
        end
        return acc;
    endfunction

    // CORDIC start value in Q.60 for a given number of steps
    function automatic t_q64 f_x0(input int steps);
        t_q64 g;
        int i;
        g = $signed(ONE_Q62);
        for (i = 0; i < 64; i++) begin
            if (i < steps) begin
                g = f_mulq(g, $signed(f_gain(i)), 62);
            end
        end
        return (g + 64'sd2) >>> 2;
    endfunction

endpackage

FILE: rtl/pmx_mul.sv
// Pipelined signed 64x64 multiplier with rounding right shift and saturation.
`timescale 1ns / 1ps

module pmx_mul #(
    parameter int SHIFT = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  pmx_pkg::t_q64 i_a,
    input  pmx_pkg::t_q64 i_b,
    output pmx_pkg::t_q64 o_p
);

    logic          r_neg_a, r_neg_b, r_neg_c;
    logic [63:0]   r_ua, r_ub;
    logic [63:0]   r_p00, r_p01, r_p10, r_p11;
    logic [127:0]  r_sum;
    pmx_pkg::t_q64 r_p;

    logic [127:0]  n_sum;
    logic [127:0]  w_sh;
    logic [63:0]   w_mag;

    always_comb begin
        n_sum = {r_p11, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
              + (128'd1 << (SHIFT - 1));
        w_sh  = r_sum >> SHIFT;
        w_mag = (|w_sh[127:63]) ? 64'h7FFFFFFFFFFFFFFF : w_sh[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= i_a[63] ^ i_b[63];
            r_ua    <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ub    <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_p00   <= 64'(r_ua[31:0])  * 64'(r_ub[31:0]);
            r_p01   <= 64'(r_ua[31:0])  * 64'(r_ub[63:32]);
            r_p10   <= 64'(r_ua[63:32]) * 64'(r_ub[31:0]);
            r_p11   <= 64'(r_ua[63:32]) * 64'(r_ub[63:32]);
            r_neg_b <= r_neg_a;
            r_sum   <= n_sum;
            r_neg_c <= r_neg_b;
            r_p     <= r_neg_c ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/pmx_dly.sv
// Enabled delay line for pipeline alignment.
`timescale 1ns / 1ps

module pmx_dly #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

FILE: rtl/pmx_div.sv
// Rounded constant divide of the scaled arcsecond sum by reciprocal multiplication.
`timescale 1ns / 1ps

module pmx_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  pmx_pkg::t_q64 i_num,
    output pmx_pkg::t_q64 o_quo
);

    // reciprocal error stays below half a quotient step for |i_num| < 2^60
    pmx_mul #(.SHIFT(pmx_pkg::ARC_SHIFT)) u_mul (.i_clk, .i_en, .i_a(i_num),
                                                 .i_b(pmx_pkg::ARC_RECIP), .o_p(o_quo));

endmodule

FILE: rtl/pmx_cell.sv
// One CORDIC rotation cell: a single micro-rotation per pipeline stage.
`timescale 1ns / 1ps

module pmx_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  pmx_pkg::t_rot i_rot,
    output pmx_pkg::t_rot o_rot
);

    localparam pmx_pkg::t_q64 ATAN = pmx_pkg::f_atan_pow2(STEP);

    pmx_pkg::t_rot r_rot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_rot.a[63]) begin
                r_rot.x <= i_rot.x - (i_rot.y >>> STEP);
                r_rot.y <= i_rot.y + (i_rot.x >>> STEP);
                r_rot.a <= i_rot.a - ATAN;
            end else begin
                r_rot.x <= i_rot.x + (i_rot.y >>> STEP);
                r_rot.y <= i_rot.y - (i_rot.x >>> STEP);
                r_rot.a <= i_rot.a + ATAN;
            end
            r_rot.flip <= i_rot.flip;
        end
    end

    assign o_rot = r_rot;

endmodule

FILE: rtl/precession_matrix_from_epoch_time.sv
// Top level: epoch in, precession rotation matrix out, fully pipelined.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  epoch in | i_valid / o_ready   | i_time_centuries  (signed Q8.32)
//  matrix   | o_valid / i_ready   | o_m00 .. o_m22    (signed Q1.30, saturated)
//
// One epoch enters per cycle while the pipeline is not held. The latency from transfer in to
// o_valid is set by the CORDIC cell chain and seven multiplier passes, the constant divide
// among them. Reset clears only the valid line and the output flag.
// The pipeline holds as a whole only when its last stage is full and the output
// register still waits for a transfer; otherwise new epochs keep entering.
`timescale 1ns / 1ps

module precession_matrix_from_epoch_time #(
    parameter int CORDIC_STEPS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [39:0] i_time_centuries,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_m00,
    output logic signed [31:0] o_m01,
    output logic signed [31:0] o_m02,
    output logic signed [31:0] o_m10,
    output logic signed [31:0] o_m11,
    output logic signed [31:0] o_m12,
    output logic signed [31:0] o_m20,
    output logic signed [31:0] o_m21,
    output logic signed [31:0] o_m22
);

    localparam int ML  = pmx_pkg::MUL_LAT;
    localparam int LAT = 1 + 3 * ML + 1 + 2 * ML + 1
                       + CORDIC_STEPS + 1 + 2 * ML + 2;
    localparam pmx_pkg::t_q64 X0 = pmx_pkg::f_x0(CORDIC_STEPS);

    function automatic pmx_pkg::t_entry f_entry(input pmx_pkg::t_q64 v);
        pmx_pkg::t_q64 q;
        q = (v + pmx_pkg::ROUND_Q30) >>> 30;
        if (q > pmx_pkg::ENTRY_MAX) begin
            q = pmx_pkg::ENTRY_MAX;
        end
        if (q < pmx_pkg::ENTRY_MIN) begin
            q = pmx_pkg::ENTRY_MIN;
        end
        return q[31:0];
    endfunction

    logic              w_en;
    logic [LAT-1:0]    r_vld;
    logic              r_ov;
    pmx_pkg::t_entry   r_m   [9];
    pmx_pkg::t_entry   r_out [9];

    // stall only when the last stage is full and the output slot cannot drain
    assign w_en    = !(r_vld[LAT-1] && r_ov && !i_ready);
    assign o_ready = w_en;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_valid};
            end
            if (w_en && r_vld[LAT-1]) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[LAT-1]) begin
            r_out <= r_m;
        end
    end

    // powers of T
    pmx_pkg::t_q64 r_t1, w_t2, w_t3, w_t1_d4, w_t1_d8, w_t2_d4;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1 <= pmx_pkg::t_q64'(i_time_centuries);
        end
    end

    pmx_mul #(.SHIFT(32)) u_mul_t2 (.i_clk, .i_en(w_en), .i_a(r_t1), .i_b(r_t1), .o_p(w_t2));
    pmx_dly #(.WIDTH(64), .DEPTH(ML)) u_dly_t1a (.i_clk, .i_en(w_en), .i_d(r_t1), .o_q(w_t1_d4));
    pmx_mul #(.SHIFT(32)) u_mul_t3 (.i_clk, .i_en(w_en), .i_a(w_t2), .i_b(w_t1_d4), .o_p(w_t3));
    pmx_dly #(.WIDTH(64), .DEPTH(ML)) u_dly_t1b (.i_clk, .i_en(w_en), .i_d(w_t1_d4),
                                                 .o_q(w_t1_d8));
    pmx_dly #(.WIDTH(64), .DEPTH(ML)) u_dly_t2 (.i_clk, .i_en(w_en), .i_d(w_t2), .o_q(w_t2_d4));

    // lanes: 0 zeta, 1 theta, 2 z
    pmx_pkg::t_q64 r_sin [3];
    pmx_pkg::t_q64 r_cos [3];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        pmx_pkg::t_q64               w_p1, w_p2, w_p3, w_d, w_rad;
        pmx_pkg::t_q64               r_arc;
        pmx_pkg::t_rot               r_rot0;
        pmx_pkg::t_rot               w_rot [CORDIC_STEPS+1];

        pmx_mul #(.SHIFT(32)) u_mul_c1 (.i_clk, .i_en(w_en), .i_a(pmx_pkg::COEF1[l]),
                                        .i_b(w_t1_d8), .o_p(w_p1));
        pmx_mul #(.SHIFT(32)) u_mul_c2 (.i_clk, .i_en(w_en), .i_a(pmx_pkg::COEF2[l]),
                                        .i_b(w_t2_d4), .o_p(w_p2));
        pmx_mul #(.SHIFT(32)) u_mul_c3 (.i_clk, .i_en(w_en), .i_a(pmx_pkg::COEF3[l]),
                                        .i_b(w_t3), .o_p(w_p3));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_arc <= w_p1 + w_p2 + w_p3;
            end
        end

        // arcseconds to Q.44 with a common factor of 64 taken out of 4096 / 648000
        pmx_div u_div (.i_clk, .i_en(w_en), .i_num(r_arc <<< 6), .o_quo(w_d));

        pmx_mul #(.SHIFT(49)) u_mul_pi (.i_clk, .i_en(w_en), .i_a(w_d),
                                        .i_b(pmx_pkg::PI_Q61), .o_p(w_rad));

        // fold angles beyond a quarter turn, negate the result later
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rot0.x <= X0;
                r_rot0.y <= '0;
                priority if (w_rad > pmx_pkg::HALF_PI_Q56) begin
                    r_rot0.a    <= w_rad - pmx_pkg::PI_Q56;
                    r_rot0.flip <= 1'b1;
                end else if (w_rad < -pmx_pkg::HALF_PI_Q56) begin
                    r_rot0.a    <= w_rad + pmx_pkg::PI_Q56;
                    r_rot0.flip <= 1'b1;
                end else begin
                    r_rot0.a    <= w_rad;
                    r_rot0.flip <= 1'b0;
                end
            end
        end

        assign w_rot[0] = r_rot0;

        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
            pmx_cell #(.STEP(k)) u_cell (.i_clk, .i_en(w_en), .i_rot(w_rot[k]),
                                         .o_rot(w_rot[k+1]));
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sin[l] <= w_rot[CORDIC_STEPS].flip ? -w_rot[CORDIC_STEPS].y
                                                     : w_rot[CORDIC_STEPS].y;
                r_cos[l] <= w_rot[CORDIC_STEPS].flip ? -w_rot[CORDIC_STEPS].x
                                                     : w_rot[CORDIC_STEPS].x;
            end
        end
    end

    // first product row: ct*cz, sz*ct, sze*ct, sz*sze, sze*cz, cze*sz, cz*cze,
    // cze*st, sze*st, st*cz, st*sz
    pmx_pkg::t_q64 w_ma [11];
    pmx_pkg::t_q64 w_mb [11];
    pmx_pkg::t_q64 w_pa [11];

    always_comb begin
        w_ma[0]  = r_cos[1]; w_mb[0]  = r_cos[2];
        w_ma[1]  = r_sin[2]; w_mb[1]  = r_cos[1];
        w_ma[2]  = r_sin[0]; w_mb[2]  = r_cos[1];
        w_ma[3]  = r_sin[2]; w_mb[3]  = r_sin[0];
        w_ma[4]  = r_sin[0]; w_mb[4]  = r_cos[2];
        w_ma[5]  = r_cos[0]; w_mb[5]  = r_sin[2];
        w_ma[6]  = r_cos[2]; w_mb[6]  = r_cos[0];
        w_ma[7]  = r_cos[0]; w_mb[7]  = r_sin[1];
        w_ma[8]  = r_sin[0]; w_mb[8]  = r_sin[1];
        w_ma[9]  = r_sin[1]; w_mb[9]  = r_cos[2];
        w_ma[10] = r_sin[1]; w_mb[10] = r_sin[2];
    end

    for (genvar m = 0; m < 11; m++) begin : g_mat_a
        pmx_mul #(.SHIFT(60)) u_mul (.i_clk, .i_en(w_en), .i_a(w_ma[m]), .i_b(w_mb[m]),
                                     .o_p(w_pa[m]));
    end

    // cosines for the second row, plus ct for the corner entry
    logic [191:0]  w_cs_d4;
    logic [63:0]   w_ct_d8;
    pmx_pkg::t_q64 w_ct4, w_cz4, w_cze4;

    pmx_dly #(.WIDTH(192), .DEPTH(ML)) u_dly_cos (.i_clk, .i_en(w_en),
        .i_d({r_cos[1], r_cos[2], r_cos[0]}), .o_q(w_cs_d4));

    assign w_ct4  = $signed(w_cs_d4[191:128]);
    assign w_cz4  = $signed(w_cs_d4[127:64]);
    assign w_cze4 = $signed(w_cs_d4[63:0]);

    pmx_dly #(.WIDTH(64), .DEPTH(ML)) u_dly_ct (.i_clk, .i_en(w_en), .i_d(w_ct4),
                                                .o_q(w_ct_d8));

    pmx_pkg::t_q64 w_mc [4];
    pmx_pkg::t_q64 w_md [4];
    pmx_pkg::t_q64 w_pb [4];

    always_comb begin
        w_mc[0] = w_pa[0]; w_md[0] = w_cze4;
        w_mc[1] = w_pa[1]; w_md[1] = w_cze4;
        w_mc[2] = w_pa[2]; w_md[2] = w_cz4;
        w_mc[3] = w_pa[3]; w_md[3] = w_ct4;
    end

    for (genvar m = 0; m < 4; m++) begin : g_mat_b
        pmx_mul #(.SHIFT(60)) u_mul (.i_clk, .i_en(w_en), .i_a(w_mc[m]), .i_b(w_md[m]),
                                     .o_p(w_pb[m]));
    end

    // align single products with the second row
    logic [511:0]  w_pk, w_pk_d;
    pmx_pkg::t_q64 w_pd [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_pk[k*64 +: 64] = w_pa[k+3];
            w_pd[k]          = $signed(w_pk_d[k*64 +: 64]);
        end
    end

    pmx_dly #(.WIDTH(512), .DEPTH(ML)) u_dly_prod (.i_clk, .i_en(w_en), .i_d(w_pk),
                                                   .o_q(w_pk_d));

    pmx_pkg::t_q64 r_e [9];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e[0] <= w_pb[0] - w_pd[0];
            r_e[1] <= w_pb[1] + w_pd[1];
            r_e[2] <= w_pd[4];
            r_e[3] <= -w_pb[2] - w_pd[2];
            r_e[4] <= w_pd[3] - w_pb[3];
            r_e[5] <= -w_pd[5];
            r_e[6] <= -w_pd[6];
            r_e[7] <= -w_pd[7];
            r_e[8] <= $signed(w_ct_d8);
            for (int k = 0; k < 9; k++) begin
                r_m[k] <= f_entry(r_e[k]);
            end
        end
    end

    assign o_m00 = r_out[0];
    assign o_m01 = r_out[1];
    assign o_m02 = r_out[2];
    assign o_m10 = r_out[3];
    assign o_m11 = r_out[4];
    assign o_m12 = r_out[5];
    assign o_m20 = r_out[6];
    assign o_m21 = r_out[7];
    assign o_m22 = r_out[8];

endmodule

FILE: rtl/pmx_chk.sv
// Port-level checker for the precession matrix block, bound to the top level.
`timescale 1ns / 1ps

module pmx_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_m00,
    input logic signed [31:0] o_m11,
    input logic signed [31:0] o_m22
);

    // reset empties the output slot
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // an empty output slot never blocks the input side
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // a result not transferred holds: o_valid stays high and o_m00 and o_m22 stay stable
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_m00) && $stable(o_m22))
        else $error("result dropped or changed while stalled");

    // diagonal entries stay saturated to unit range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_m00 <= 32'sh40000000 && o_m00 >= -32'sh40000000
                 && o_m11 <= 32'sh40000000 && o_m11 >= -32'sh40000000
                 && o_m22 <= 32'sh40000000 && o_m22 >= -32'sh40000000)
        else $error("matrix entry beyond unit range");

endmodule

bind precession_matrix_from_epoch_time pmx_chk u_pmx_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_m00   (o_m00),
    .o_m11   (o_m11),
    .o_m22   (o_m22)
);
